>>> sv/aalr_pkg.sv
// Shared constants, types and command/status structs of the antialiased line rasterizer.
package aalr_pkg;

   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 16;
   localparam int COVER_BITS   = 8;
   localparam int OUT_BITS     = COORD_BITS + 1;
   localparam int MINOR_BITS   = COORD_BITS + 2;
   localparam int ACC_BITS     = MINOR_BITS + FRAC_BITS;
   localparam int QUO_BITS     = FRAC_BITS + 1;
   localparam int GRAD_BITS    = QUO_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(QUO_BITS);
   localparam int PROD_BITS    = FRAC_BITS + COVER_BITS + 1;

   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST   = DIV_CNT_BITS'(QUO_BITS - 1);
   localparam logic [COVER_BITS-1:0]   CMAX       = '1;
   localparam logic [COVER_BITS-1:0]   HALF_COVER = COVER_BITS'(1) << (COVER_BITS - 1);
   localparam logic [COVER_BITS-1:0]   NO_COVER   = '0;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [OUT_BITS-1:0]   out_coord_type;
   typedef logic [COVER_BITS-1:0] cover_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DIV,
      ST_LSTART,
      ST_LEND,
      ST_LMID
   } state_type;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_RUN,
      KIND_LINE
   } kind_type;

   typedef enum logic [1:0] {
      EMIT_RUN,
      EMIT_LSTART,
      EMIT_LEND,
      EMIT_LMID
   } emit_sel_type;

   typedef struct packed {
      logic         start;
      logic         emit;
      emit_sel_type emit_sel;
      logic         div_step;
      logic         pop;
   } cmd_type;

   typedef struct packed {
      kind_type start_kind;
      logic     div_last;
      logic     run_two;
      logic     run_done2;
      logic     line_short;
      logic     mid_done;
   } status_type;

   typedef struct packed {
      out_coord_type x;
      out_coord_type y;
      cover_type     cov;
      logic          last;
      logic          done;
   } pixel_type;

endpackage

>>> sv/aalr_ctrl.sv
// Controller: line/run sequencing, divide wait and result buffer occupancy.
module aalr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  aalr_pkg::status_type  status,
   output aalr_pkg::cmd_type     cmd
);

   aalr_pkg::state_type state_ff, state_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [1:0]          nres;
   logic                can_load;
   logic                accept;
   logic                step_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aalr_pkg::ST_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      nres         = 2'd0;
      rsp_valid    = (cnt_ff != 2'd0);
      cmd.pop      = rsp_valid && !rsp_stall;
      can_load     = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && cmd.pop);
      req_stall    = (state_ff == aalr_pkg::ST_DIV) || !can_load;
      accept       = req_valid && !req_stall;
      step_acc     = accept && (req_op == aalr_pkg::OP_STEP);
      cmd.start    = accept && (req_op == aalr_pkg::OP_START);
      cmd.div_step = (state_ff == aalr_pkg::ST_DIV);
      cmd.emit     = 1'b0;
      cmd.emit_sel = aalr_pkg::EMIT_RUN;

      case (state_ff)
         aalr_pkg::ST_IDLE: begin
            state_in = aalr_pkg::ST_IDLE;
         end
         aalr_pkg::ST_RUN: begin
            cmd.emit     = step_acc;
            cmd.emit_sel = aalr_pkg::EMIT_RUN;
            if (step_acc) begin
               nres = status.run_two ? 2'd2 : 2'd1;
               if (!status.run_two || status.run_done2) begin
                  state_in = aalr_pkg::ST_IDLE;
               end
            end
         end
         aalr_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = aalr_pkg::ST_LSTART;
            end
         end
         aalr_pkg::ST_LSTART: begin
            cmd.emit     = step_acc;
            cmd.emit_sel = aalr_pkg::EMIT_LSTART;
            if (step_acc) begin
               nres     = 2'd2;
               state_in = aalr_pkg::ST_LEND;
            end
         end
         aalr_pkg::ST_LEND: begin
            cmd.emit     = step_acc;
            cmd.emit_sel = aalr_pkg::EMIT_LEND;
            if (step_acc) begin
               nres     = 2'd2;
               state_in = status.line_short ? aalr_pkg::ST_IDLE : aalr_pkg::ST_LMID;
            end
         end
         aalr_pkg::ST_LMID: begin
            cmd.emit     = step_acc;
            cmd.emit_sel = aalr_pkg::EMIT_LMID;
            if (step_acc) begin
               nres = 2'd2;
               if (status.mid_done) begin
                  state_in = aalr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = aalr_pkg::ST_IDLE;
         end
      endcase

      // a start item aborts whatever line is in progress
      if (cmd.start) begin
         case (status.start_kind)
            aalr_pkg::KIND_RUN:  state_in = aalr_pkg::ST_RUN;
            aalr_pkg::KIND_LINE: state_in = aalr_pkg::ST_DIV;
            default:             state_in = aalr_pkg::ST_IDLE;
         endcase
      end

      if (cmd.emit) begin
         cnt_in = nres;
      end else if (cmd.pop) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

endmodule

>>> sv/aalr_dp.sv
// Datapath: endpoint setup, serial gradient divider, intercept walk and result buffer.
module aalr_dp (
   input  logic                       clock,
   input  aalr_pkg::coord_type        req_x_start,
   input  aalr_pkg::coord_type        req_y_start,
   input  aalr_pkg::coord_type        req_x_end,
   input  aalr_pkg::coord_type        req_y_end,
   input  aalr_pkg::cmd_type          cmd,
   output aalr_pkg::status_type       status,
   output aalr_pkg::pixel_type        rsp_pixel
);

   // line state
   logic                                 steep_ff, steep_in;
   aalr_pkg::coord_type                  base_major_ff, base_major_in;
   aalr_pkg::coord_type                  base_minor_ff, base_minor_in;
   aalr_pkg::out_coord_type              len_ff, len_in;
   aalr_pkg::out_coord_type              delta_ff, delta_in;
   logic [aalr_pkg::GRAD_BITS-1:0]       grad_ff, grad_in;
   logic [aalr_pkg::ACC_BITS-1:0]        acc_ff, acc_in;
   aalr_pkg::out_coord_type              column_ff, column_in;
   // divider
   aalr_pkg::coord_type                  rem_ff, rem_in;
   logic [aalr_pkg::QUO_BITS-1:0]        quo_ff, quo_in;
   logic [aalr_pkg::DIV_CNT_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic                                 div_bit_ff, div_bit_in;
   logic                                 neg_ff, neg_in;
   // result buffer
   aalr_pkg::pixel_type                  out0_ff, out0_in;
   aalr_pkg::pixel_type                  out1_ff, out1_in;

   // start setup
   aalr_pkg::coord_type                  adx, ady;
   logic                                 steep_l, swap_l;
   aalr_pkg::coord_type                  a0, a1, b0, b1;
   aalr_pkg::coord_type                  bmaj_l, bmin_l, emin_l;
   aalr_pkg::kind_type                   kind_l;
   // divide step
   aalr_pkg::out_coord_type              div_t, div_diff;
   logic                                 div_ge;
   logic [aalr_pkg::GRAD_BITS-1:0]       grad_mag;
   // pixel generation
   aalr_pkg::out_coord_type              mj_col, mj_col1, mj_end, mn_base, mn_end;
   logic [aalr_pkg::MINOR_BITS-1:0]      mn_mid;
   logic [aalr_pkg::FRAC_BITS-1:0]       frac;
   logic [aalr_pkg::PROD_BITS-1:0]       prod;
   aalr_pkg::cover_type                  chi;
   logic [aalr_pkg::ACC_BITS-1:0]        grad_ext;
   aalr_pkg::pixel_type                  p0, p1;

   function automatic aalr_pkg::pixel_type place(
      input logic                    steep,
      input aalr_pkg::out_coord_type mj,
      input aalr_pkg::out_coord_type mn,
      input aalr_pkg::cover_type     cov,
      input logic                    last,
      input logic                    done
   );
      aalr_pkg::pixel_type p;
      p.x    = steep ? mn : mj;
      p.y    = steep ? mj : mn;
      p.cov  = cov;
      p.last = last;
      p.done = done;
      return p;
   endfunction

   always_ff @(posedge clock) begin
      steep_ff      <= steep_in;
      base_major_ff <= base_major_in;
      base_minor_ff <= base_minor_in;
      len_ff        <= len_in;
      delta_ff      <= delta_in;
      grad_ff       <= grad_in;
      acc_ff        <= acc_in;
      column_ff     <= column_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      div_bit_ff    <= div_bit_in;
      neg_ff        <= neg_in;
      out0_ff       <= out0_in;
      out1_ff       <= out1_in;
   end

   // endpoint classification and ordering
   always_comb begin
      adx     = (req_x_start < req_x_end) ? req_x_end - req_x_start : req_x_start - req_x_end;
      ady     = (req_y_start < req_y_end) ? req_y_end - req_y_start : req_y_start - req_y_end;
      steep_l = (ady > adx);
      a0      = steep_l ? req_y_start : req_x_start;
      a1      = steep_l ? req_y_end   : req_x_end;
      b0      = steep_l ? req_x_start : req_y_start;
      b1      = steep_l ? req_x_end   : req_y_end;
      swap_l  = (a0 > a1);
      bmaj_l  = swap_l ? a1 : a0;
      bmin_l  = swap_l ? b1 : b0;
      emin_l  = swap_l ? b0 : b1;

      if (req_y_start == req_y_end) begin
         kind_l = (adx == '0) ? aalr_pkg::KIND_EMPTY : aalr_pkg::KIND_RUN;
      end else if (req_x_start == req_x_end) begin
         kind_l = aalr_pkg::KIND_RUN;
      end else begin
         kind_l = aalr_pkg::KIND_LINE;
      end
   end

   // one quotient bit per cycle; the remainder always stays below the divisor
   always_comb begin
      div_t    = {rem_ff, div_bit_ff};
      div_ge   = (div_t >= len_ff);
      div_diff = div_t - len_ff;
      grad_mag = {1'b0, quo_ff[aalr_pkg::QUO_BITS-2:0], div_ge};
   end

   // pixel pair for the current step
   always_comb begin
      mn_base  = {1'b0, base_minor_ff};
      mj_col   = {1'b0, base_major_ff} + column_ff;
      mj_col1  = mj_col + aalr_pkg::OUT_BITS'(1);
      mj_end   = {1'b0, base_major_ff} + len_ff;
      mn_end   = mn_base + delta_ff;
      frac     = acc_ff[aalr_pkg::FRAC_BITS-1:0];
      mn_mid   = {2'b00, base_minor_ff} + acc_ff[aalr_pkg::ACC_BITS-1:aalr_pkg::FRAC_BITS];
      prod     = aalr_pkg::PROD_BITS'(frac) * aalr_pkg::PROD_BITS'(aalr_pkg::CMAX)
               + (aalr_pkg::PROD_BITS'(1) << (aalr_pkg::FRAC_BITS - 1));
      chi      = prod[aalr_pkg::FRAC_BITS +: aalr_pkg::COVER_BITS];
      grad_ext = {{(aalr_pkg::ACC_BITS - aalr_pkg::GRAD_BITS){grad_ff[aalr_pkg::GRAD_BITS-1]}},
                  grad_ff};

      status.start_kind = kind_l;
      status.div_last   = (div_cnt_ff == aalr_pkg::DIV_LAST);
      status.run_two    = (column_ff + aalr_pkg::OUT_BITS'(1)) < len_ff;
      status.run_done2  = (column_ff + aalr_pkg::OUT_BITS'(2)) >= len_ff;
      status.line_short = (len_ff <= aalr_pkg::OUT_BITS'(1));
      status.mid_done   = (column_ff + aalr_pkg::OUT_BITS'(1)) >= len_ff;

      case (cmd.emit_sel)
         aalr_pkg::EMIT_RUN: begin
            p0 = place(steep_ff, mj_col, mn_base, aalr_pkg::CMAX,
                       !status.run_two, !status.run_two);
            p1 = place(steep_ff, mj_col1, mn_base, aalr_pkg::CMAX, 1'b1, status.run_done2);
         end
         aalr_pkg::EMIT_LSTART: begin
            p0 = place(steep_ff, mj_col, mn_base, aalr_pkg::HALF_COVER, 1'b0, 1'b0);
            p1 = place(steep_ff, mj_col, mn_base + aalr_pkg::OUT_BITS'(1),
                       aalr_pkg::NO_COVER, 1'b1, 1'b0);
         end
         aalr_pkg::EMIT_LEND: begin
            p0 = place(steep_ff, mj_end, mn_end, aalr_pkg::HALF_COVER, 1'b0, 1'b0);
            p1 = place(steep_ff, mj_end, mn_end + aalr_pkg::OUT_BITS'(1),
                       aalr_pkg::NO_COVER, 1'b1, status.line_short);
         end
         default: begin
            p0 = place(steep_ff, mj_col, mn_mid[aalr_pkg::OUT_BITS-1:0],
                       aalr_pkg::CMAX - chi, 1'b0, 1'b0);
            p1 = place(steep_ff, mj_col,
                       mn_mid[aalr_pkg::OUT_BITS-1:0] + aalr_pkg::OUT_BITS'(1),
                       chi, 1'b1, status.mid_done);
         end
      endcase
   end

   // register updates
   always_comb begin
      steep_in      = steep_ff;
      base_major_in = base_major_ff;
      base_minor_in = base_minor_ff;
      len_in        = len_ff;
      delta_in      = delta_ff;
      grad_in       = grad_ff;
      acc_in        = acc_ff;
      column_in     = column_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      div_bit_in    = div_bit_ff;
      neg_in        = neg_ff;
      out0_in       = out0_ff;
      out1_in       = out1_ff;

      if (cmd.start) begin
         column_in = '0;
         if (status.start_kind == aalr_pkg::KIND_LINE) begin
            steep_in      = steep_l;
            base_major_in = bmaj_l;
            base_minor_in = bmin_l;
            len_in        = {1'b0, steep_l ? ady : adx};
            delta_in      = {1'b0, emin_l} - {1'b0, bmin_l};
            neg_in        = (emin_l < bmin_l);
            acc_in        = '0;
            // dividend is |delta| shifted up by the fraction width; seed with its top part
            rem_in        = (steep_l ? adx : ady) >> 1;
            div_bit_in    = steep_l ? adx[0] : ady[0];
            quo_in        = '0;
            div_cnt_in    = '0;
         end else if (req_y_start == req_y_end) begin
            steep_in      = 1'b0;
            base_major_in = (req_x_start < req_x_end) ? req_x_start : req_x_end;
            base_minor_in = req_y_start;
            len_in        = {1'b0, adx};
         end else begin
            steep_in      = 1'b1;
            base_major_in = (req_y_start < req_y_end) ? req_y_start : req_y_end;
            base_minor_in = req_x_start;
            len_in        = {1'b0, ady};
         end
      end

      if (cmd.div_step) begin
         rem_in     = div_ge ? div_diff[aalr_pkg::COORD_BITS-1:0]
                             : div_t[aalr_pkg::COORD_BITS-1:0];
         quo_in     = {quo_ff[aalr_pkg::QUO_BITS-2:0], div_ge};
         div_bit_in = 1'b0;
         div_cnt_in = div_cnt_ff + aalr_pkg::DIV_CNT_BITS'(1);
         if (status.div_last) begin
            grad_in = neg_ff ? -grad_mag : grad_mag;
         end
      end

      if (cmd.emit) begin
         out0_in = p0;
         out1_in = p1;
         case (cmd.emit_sel)
            aalr_pkg::EMIT_RUN: begin
               column_in = column_ff + aalr_pkg::OUT_BITS'(2);
            end
            aalr_pkg::EMIT_LSTART: begin
               acc_in    = grad_ext;
               column_in = aalr_pkg::OUT_BITS'(1);
            end
            aalr_pkg::EMIT_LMID: begin
               acc_in    = acc_ff + grad_ext;
               column_in = column_ff + aalr_pkg::OUT_BITS'(1);
            end
            default: begin
               column_in = column_ff;
            end
         endcase
      end else if (cmd.pop) begin
         // advance the second pixel to the head
         out0_in = out1_ff;
      end
   end

   assign rsp_pixel = out0_ff;

endmodule

>>> sv/antialiased_line_rasterizer.sv
// Antialiased line rasterizer: step items produce one or two pixels (none while idle),
// one result per cycle while the result side does not stall. A step item's first pixel is
// presented the cycle after acceptance; a new item is taken only once the result buffer is
// empty or its last pixel is being read out. A start item for a sloped line holds the input
// stalled for the serial gradient divider (one quotient bit per cycle); a run or empty
// start needs no divide. Synchronous reset idles the sequencer and empties the result buffer.
module antialiased_line_rasterizer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  aalr_pkg::coord_type        req_x_start,
   input  aalr_pkg::coord_type        req_y_start,
   input  aalr_pkg::coord_type        req_x_end,
   input  aalr_pkg::coord_type        req_y_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output aalr_pkg::out_coord_type    rsp_pixel_x,
   output aalr_pkg::out_coord_type    rsp_pixel_y,
   output aalr_pkg::cover_type        rsp_coverage,
   output logic                       rsp_last_of_step,
   output logic                       rsp_line_done
);

   aalr_pkg::cmd_type    cmd;
   aalr_pkg::status_type status;
   aalr_pkg::pixel_type  pixel;

   aalr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aalr_dp u_dp (
      .clock       (clock),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .cmd         (cmd),
      .status      (status),
      .rsp_pixel   (pixel)
   );

   assign rsp_pixel_x      = pixel.x;
   assign rsp_pixel_y      = pixel.y;
   assign rsp_coverage     = pixel.cov;
   assign rsp_last_of_step = pixel.last;
   assign rsp_line_done    = pixel.done;

   a_start_pair_half : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_sel == aalr_pkg::EMIT_LSTART) |=>
         (rsp_valid && rsp_coverage == aalr_pkg::HALF_COVER && !rsp_last_of_step))
      else $error("start endpoint pair not presented at half coverage");

   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_done) |-> rsp_last_of_step)
      else $error("line done flagged on a pixel that does not end its step");

   a_start_empties : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == aalr_pkg::OP_START) |=> !rsp_valid)
      else $error("results pending after a start item");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the antialiased line rasterizer: directed table, then random lines.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CLOCK_HALF   = 6;
   localparam int     LIMIT_CYCLES = 400000;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     ITEM_TARGET  = 1500;
   localparam int     MAX_COORD    = (1 << aalr_pkg::COORD_BITS) - 1;
   localparam longint CMAX_L       = (longint'(1) << aalr_pkg::COVER_BITS) - 1;
   localparam longint HALF_L       = (CMAX_L + 1) >> 1;
   localparam longint FONE_L       = longint'(1) << aalr_pkg::FRAC_BITS;

   typedef enum logic [1:0] {LN_IDLE, LN_RUN, LN_SLOPE} line_mode_type;
   typedef enum logic [1:0] {PH_FIRST, PH_LAST, PH_MID} line_phase_type;

   // one directed item; typed rows carry their own expected pixels
   typedef struct packed {
      logic                op;
      aalr_pkg::coord_type xs;
      aalr_pkg::coord_type ys;
      aalr_pkg::coord_type xe;
      aalr_pkg::coord_type ye;
      logic                typed;
      logic [1:0]          tn;
      aalr_pkg::pixel_type t0;
      aalr_pkg::pixel_type t1;
   } dir_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_op;
   aalr_pkg::coord_type     req_x_start;
   aalr_pkg::coord_type     req_y_start;
   aalr_pkg::coord_type     req_x_end;
   aalr_pkg::coord_type     req_y_end;
   logic                    rsp_valid;
   logic                    rsp_stall;
   aalr_pkg::out_coord_type rsp_pixel_x;
   aalr_pkg::out_coord_type rsp_pixel_y;
   aalr_pkg::cover_type     rsp_coverage;
   logic                    rsp_last_of_step;
   logic                    rsp_line_done;

   antialiased_line_rasterizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_coverage     (rsp_coverage),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_line_done    (rsp_line_done)
   );

   aalr_pkg::pixel_type due_pixels[$];
   int          errors = 0;
   int          real_items = 0;
   int          cycles = 0;
   bit          tx_calm = 0;
   bit          rx_calm = 0;
   bit          rx_hold = 0;

   // line tracer state
   line_mode_type  ln_mode;
   line_phase_type ln_phase;
   bit          ln_steep;
   int          ln_major0, ln_minor0, ln_len, ln_dminor, ln_col;
   longint      ln_slope, ln_icpt;

   dir_row_type directed_rows [27] = '{
      // step while idle after reset
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd0, '0, '0},
      // horizontal run of three
      '{aalr_pkg::OP_START, 12'd0,    12'd5,    12'd3,    12'd5,    1'b1, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2,
        '{13'd0, 13'd5, 8'd255, 1'b0, 1'b0}, '{13'd1, 13'd5, 8'd255, 1'b1, 1'b0}},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd1,
        '{13'd2, 13'd5, 8'd255, 1'b1, 1'b1}, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd0, '0, '0},
      // vertical run, reversed, at the far corner
      '{aalr_pkg::OP_START, 12'd4095, 12'd4095, 12'd4095, 12'd4093, 1'b1, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2,
        '{13'd4095, 13'd4093, 8'd255, 1'b0, 1'b0},
        '{13'd4095, 13'd4094, 8'd255, 1'b1, 1'b1}},
      // both endpoints equal: empty
      '{aalr_pkg::OP_START, 12'd7,    12'd7,    12'd7,    12'd7,    1'b1, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd0, '0, '0},
      // full diagonal; end pair reaches one past the coordinate range
      '{aalr_pkg::OP_START, 12'd0,    12'd0,    12'd4095, 12'd4095, 1'b1, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2,
        '{13'd0, 13'd0, 8'd128, 1'b0, 1'b0}, '{13'd0, 13'd1, 8'd0, 1'b1, 1'b0}},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2,
        '{13'd4095, 13'd4095, 8'd128, 1'b0, 1'b0},
        '{13'd4095, 13'd4096, 8'd0, 1'b1, 1'b0}},
      // aborts the diagonal; length one line drawn backwards
      '{aalr_pkg::OP_START, 12'd11,   12'd11,   12'd10,   12'd10,   1'b1, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2,
        '{13'd10, 13'd10, 8'd128, 1'b0, 1'b0}, '{13'd10, 13'd11, 8'd0, 1'b1, 1'b0}},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd2,
        '{13'd11, 13'd11, 8'd128, 1'b0, 1'b0}, '{13'd11, 13'd12, 8'd0, 1'b1, 1'b1}},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 2'd0, '0, '0},
      // shallow, falling, right to left
      '{aalr_pkg::OP_START, 12'd4095, 12'd0,    12'd0,    12'd1,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      // steep with negative minor delta
      '{aalr_pkg::OP_START, 12'd100,  12'd4095, 12'd103,  12'd0,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      // fractional gradient, walked to the end
      '{aalr_pkg::OP_START, 12'd0,    12'd0,    12'd3,    12'd1,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0},
      '{aalr_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0,    1'b0, 2'd0, '0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("antialiased_line_rasterizer: mismatch");
         $finish;
      end
   end

   function automatic aalr_pkg::pixel_type place(longint major, longint minor, longint cov,
                                                 bit last, bit done);
      aalr_pkg::pixel_type px;
      px.x    = aalr_pkg::out_coord_type'(ln_steep ? minor : major);
      px.y    = aalr_pkg::out_coord_type'(ln_steep ? major : minor);
      px.cov  = aalr_pkg::cover_type'(cov);
      px.last = last;
      px.done = done;
      return px;
   endfunction

   function automatic void set_span(int minor, int a, int b, bit steep);
      ln_steep  = steep;
      ln_minor0 = minor;
      ln_major0 = a < b ? a : b;
      ln_len    = a < b ? b - a : a - b;
      ln_col    = 0;
      ln_mode   = ln_len == 0 ? LN_IDLE : LN_RUN;
   endfunction

   function automatic void clear_line();
      ln_mode   = LN_IDLE;
      ln_phase  = PH_FIRST;
      ln_steep  = 0;
      ln_major0 = 0;
      ln_minor0 = 0;
      ln_len    = 0;
      ln_dminor = 0;
      ln_col    = 0;
      ln_slope  = 0;
      ln_icpt   = 0;
   endfunction

   // advance the tracer by one item; returns how many pixels it emits
   function automatic int rasterize(input logic op, input aalr_pkg::coord_type xs, ys, xe, ye,
                                    output aalr_pkg::pixel_type p0,
                                    output aalr_pkg::pixel_type p1);
      int     ixs, iys, ixe, iye, adx, ady, a0, b0, a1, b1, t;
      longint mag, frac, fl, chi, mj, mn;
      bit     two, done;
      p0  = '0;
      p1  = '0;
      ixs = int'(xs);
      iys = int'(ys);
      ixe = int'(xe);
      iye = int'(ye);
      if (op == aalr_pkg::OP_START) begin
         if (iys == iye) begin
            set_span(iys, ixs, ixe, 1'b0);
         end else if (ixs == ixe) begin
            set_span(ixs, iys, iye, 1'b1);
         end else begin
            adx = ixs < ixe ? ixe - ixs : ixs - ixe;
            ady = iys < iye ? iye - iys : iys - iye;
            ln_steep = ady > adx;
            if (ln_steep) begin
               a0 = iys; b0 = ixs; a1 = iye; b1 = ixe;
            end else begin
               a0 = ixs; b0 = iys; a1 = ixe; b1 = iye;
            end
            if (a0 > a1) begin
               t = a0; a0 = a1; a1 = t;
               t = b0; b0 = b1; b1 = t;
            end
            ln_major0 = a0;
            ln_minor0 = b0;
            ln_len    = a1 - a0;
            ln_dminor = b1 - b0;
            // truncate toward zero so the intercept never overshoots
            mag       = (longint'(ln_dminor < 0 ? -ln_dminor : ln_dminor)
                         << aalr_pkg::FRAC_BITS) / ln_len;
            ln_slope  = ln_dminor < 0 ? -mag : mag;
            ln_icpt   = 0;
            ln_col    = 0;
            ln_phase  = PH_FIRST;
            ln_mode   = LN_SLOPE;
         end
         return 0;
      end
      case (ln_mode)
         LN_RUN: begin
            two = ln_col + 1 < ln_len;
            p0  = place(ln_major0 + ln_col, ln_minor0, CMAX_L, !two, !two);
            if (!two) begin
               ln_mode = LN_IDLE;
               return 1;
            end
            ln_col += 2;
            done = ln_col >= ln_len;
            p1   = place(ln_major0 + ln_col - 1, ln_minor0, CMAX_L, 1'b1, done);
            if (done) ln_mode = LN_IDLE;
            return 2;
         end
         LN_SLOPE: begin
            if (ln_phase == PH_FIRST) begin
               p0 = place(ln_major0, ln_minor0, HALF_L, 1'b0, 1'b0);
               p1 = place(ln_major0, ln_minor0 + 1, 0, 1'b1, 1'b0);
               ln_icpt  = ln_slope;
               ln_col   = 1;
               ln_phase = PH_LAST;
               return 2;
            end
            if (ln_phase == PH_LAST) begin
               mj   = ln_major0 + ln_len;
               mn   = ln_minor0 + ln_dminor;
               done = ln_len <= 1;
               p0   = place(mj, mn, HALF_L, 1'b0, 1'b0);
               p1   = place(mj, mn + 1, 0, 1'b1, done);
               if (done) ln_mode = LN_IDLE;
               else ln_phase = PH_MID;
               return 2;
            end
            // interior column: floor picks the lower pixel, fraction splits coverage
            frac = ln_icpt & (FONE_L - 1);
            fl   = (ln_icpt - frac) / FONE_L;
            chi  = (frac * CMAX_L + (FONE_L >> 1)) >> aalr_pkg::FRAC_BITS;
            mj   = ln_major0 + ln_col;
            mn   = ln_minor0 + fl;
            done = ln_col + 1 >= ln_len;
            p0   = place(mj, mn, CMAX_L - chi, 1'b0, 1'b0);
            p1   = place(mj, mn + 1, chi, 1'b1, done);
            ln_icpt += ln_slope;
            ln_col++;
            if (done) ln_mode = LN_IDLE;
            return 2;
         end
         default: return 0;
      endcase
   endfunction

   function automatic string show(aalr_pkg::pixel_type p);
      return $sformatf("x=%0d y=%0d cov=%0d last=%0b done=%0b",
                       p.x, p.y, p.cov, p.last, p.done);
   endfunction

   function automatic aalr_pkg::coord_type any_coord();
      return aalr_pkg::coord_type'($urandom);
   endfunction

   // move an endpoint by d in a random direction, staying on screen
   function automatic aalr_pkg::coord_type shift_coord(aalr_pkg::coord_type c, int d);
      int v;
      v = ($urandom_range(0, 1) == 1) ? int'(c) - d : int'(c) + d;
      if (v < 0 || v > MAX_COORD) v = 2 * int'(c) - v;
      if (v < 0) v = 0;
      if (v > MAX_COORD) v = MAX_COORD;
      return aalr_pkg::coord_type'(v);
   endfunction

   // present one item, wait for it to be taken, record the pixels it owes
   task automatic offer(input logic op, input aalr_pkg::coord_type xs, ys, xe, ye,
                        input logic typed, input logic [1:0] tn,
                        input aalr_pkg::pixel_type t0, input aalr_pkg::pixel_type t1);
      int                  n, gap;
      aalr_pkg::pixel_type p0, p1;
      bit                  ignored;
      req_valid   <= 1'b1;
      req_op      <= op;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      do @(posedge clock); while (req_stall);
      ignored = (op == aalr_pkg::OP_STEP) && (ln_mode == LN_IDLE);
      n = rasterize(op, xs, ys, xe, ye, p0, p1);
      if (typed) begin
         n  = int'(tn);
         p0 = t0;
         p1 = t1;
      end
      if (n > 0) due_pixels.push_back(p0);
      if (n > 1) due_pixels.push_back(p1);
      if (!ignored) real_items++;
      gap = tx_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_pixels.size() != 0);
   endtask

   // result side: per-item stall draw, calm stretches, one long hold-off on request
   initial begin
      int w;
      forever begin
         if (rx_hold) begin
            rx_hold = 0;
            w = HOLD_CYCLES;
         end else begin
            w = rx_calm ? 0 : $urandom_range(0, 8);
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      end
   end

   always @(posedge clock) begin
      aalr_pkg::pixel_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x    = rsp_pixel_x;
         got.y    = rsp_pixel_y;
         got.cov  = rsp_coverage;
         got.last = rsp_last_of_step;
         got.done = rsp_line_done;
         if (due_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel: expected none, got %s", $time, show(got));
         end else begin
            want = due_pixels.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: pixel mismatch: expected %s, got %s",
                        $time, show(want), show(got));
            end
         end
      end
   end

   initial begin
      int                  r, s, dx, dy, steps, quit_at;
      bit                  big, hold_done, pause_done;
      aalr_pkg::coord_type xs, ys, xe, ye;
      hold_done   = 0;
      pause_done  = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_op      <= aalr_pkg::OP_START;
      req_x_start <= '0;
      req_y_start <= '0;
      req_x_end   <= '0;
      req_y_end   <= '0;
      clear_line();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].op, directed_rows[i].xs, directed_rows[i].ys,
               directed_rows[i].xe, directed_rows[i].ye, directed_rows[i].typed,
               directed_rows[i].tn, directed_rows[i].t0, directed_rows[i].t1);
      drain();

      while (real_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            // noise: lone start or step with arbitrary payload
            offer(logic'($urandom_range(0, 1)), any_coord(), any_coord(), any_coord(),
                  any_coord(), 1'b0, 2'd0, '0, '0);
         end else begin
            s   = $urandom_range(0, 99);
            big = $urandom_range(0, 49) == 0;
            dx  = big ? $urandom_range(0, MAX_COORD) : $urandom_range(0, 24);
            dy  = big ? $urandom_range(0, MAX_COORD) : $urandom_range(0, 24);
            if (s < 12) dy = 0;
            else if (s < 24) dx = 0;
            else if (s < 27) begin
               dx = 0;
               dy = 0;
            end
            if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
            // block the result side while the sender keeps pushing steps
            if (!hold_done && real_items > ITEM_TARGET / 3) begin
               hold_done = 1;
               rx_hold   = 1;
               tx_calm   = 1;
               big       = 0;
               dx        = 20;
               dy        = 9;
            end
            xs = any_coord();
            ys = any_coord();
            xe = shift_coord(xs, dx);
            ye = shift_coord(ys, dy);
            offer(aalr_pkg::OP_START, xs, ys, xe, ye, 1'b0, 2'd0, '0, '0);
            quit_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 6) : (big ? 40 : 100000);
            steps   = 0;
            while (ln_mode != LN_IDLE && steps < quit_at) begin
               offer(aalr_pkg::OP_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                     1'b0, 2'd0, '0, '0);
               steps++;
            end
            if ($urandom_range(0, 9) == 0)
               offer(aalr_pkg::OP_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                     1'b0, 2'd0, '0, '0);
            if (!pause_done && real_items > 2 * ITEM_TARGET / 3) begin
               pause_done = 1;
               drain();
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("antialiased_line_rasterizer: match");
      end else begin
         $display("antialiased_line_rasterizer: mismatch");
      end
      $finish;
   end

endmodule
